// ===== src/mm4_pkg.sv =====
package mm4_pkg;

  localparam int unsigned ElemWidth = 32;
  localparam int unsigned NumLanes  = 4;
  localparam int unsigned RowWidth  = NumLanes * ElemWidth;
  localparam int unsigned ProdWidth = 2 * ElemWidth;
  localparam int unsigned AccWidth  = ProdWidth + 2;
  localparam int unsigned IdxWidth  = 2;

  typedef logic signed [ElemWidth-1:0] elem_t;
  typedef logic [RowWidth-1:0]         row_t;
  typedef logic [IdxWidth-1:0]         idx_t;

  localparam idx_t FirstIdx = '0;
  localparam idx_t LastIdx  = '1;

  typedef struct packed {
    logic vld;
    idx_t k;
  } pipe_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_first;
  } lane_ctl_t;

endpackage

// ===== src/mm4_ram.sv =====
module mm4_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AddrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/mm4_lane.sv =====
module mm4_lane import mm4_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  lane_ctl_t ctl_i,
  input  elem_t     a_i,
  input  elem_t     b_i,
  output elem_t     res_o,
  output logic      sat_o
);

  logic signed [ProdWidth-1:0] prod_d, prod_q;
  logic signed [AccWidth-1:0]  prod_ext;
  logic signed [AccWidth-1:0]  acc_d, acc_q;
  logic signed [AccWidth-1:0]  acc_shr;
  logic [AccWidth-ElemWidth:0] top_bits;
  logic                        fits;

  assign prod_d   = a_i * b_i;
  assign prod_ext = {{(AccWidth-ProdWidth){prod_q[ProdWidth-1]}}, prod_q};
  assign acc_d    = ctl_i.acc_first ? prod_ext : acc_q + prod_ext;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctl_i.acc_en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_shr  = acc_q >>> FRAC_BITS;
  assign top_bits = acc_shr[AccWidth-1:ElemWidth-1];
  assign fits     = (&top_bits) | ~(|top_bits);
  assign sat_o    = ~fits;

  always_comb begin
    if (fits) begin
      res_o = acc_shr[ElemWidth-1:0];
    end else if (acc_shr[AccWidth-1]) begin
      res_o = {1'b1, {(ElemWidth-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(ElemWidth-1){1'b1}}};
    end
  end

endmodule

// ===== src/matrix_multiply_4x4.sv =====
// Fixed-point 4x4 matrix multiplier computing C = A x B on signed Q16.16 elements.
// Eight input items load the rows of A and then of B, one row per cycle while in_valid_i
// is high; the eighth item starts the product, which comes out as four items in row order,
// each row flagged when an element was clamped. A row takes four reads of the B row memory,
// feeding four multiply and accumulate lanes, and passes the product, accumulator and done
// registers before it reaches the output register; the next row starts once that pipeline
// and the output register are empty. Loading of the next A may begin while the last row
// is still being computed or waits at the output.
module matrix_multiply_4x4 import mm4_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  elem_t       elem0_i,
  input  elem_t       elem1_i,
  input  elem_t       elem2_i,
  input  elem_t       elem3_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output elem_t       out0_o,
  output elem_t       out1_o,
  output elem_t       out2_o,
  output elem_t       out3_o,
  output logic [1:0]  row_index_o,
  output logic        last_row_o,
  output logic        saturated_o
);

  localparam logic StLoad = 1'b0;
  localparam logic StRun  = 1'b1;

  logic       state_q, state_d;
  logic [2:0] load_cnt_q, load_cnt_d;
  idx_t       row_q, row_d;
  idx_t       k_q, k_d;
  pipe_t      s1_q, s1_d, s2_q;
  logic       done_q;
  logic       busy, issue, accept;

  row_t      a_rdata, b_rdata, wdata;
  elem_t     a_elems [NumLanes];
  elem_t     b_elems [NumLanes];
  elem_t     lane_res [NumLanes];
  logic [NumLanes-1:0] lane_sat;
  elem_t     a_sel;
  lane_ctl_t lane_ctl;

  logic       out_valid_q, out_valid_d;
  elem_t      out_q [NumLanes];
  idx_t       out_row_q;
  logic       out_sat_q;

  assign accept     = in_valid_i & in_ready_o;
  assign in_ready_o = (state_q == StLoad);
  assign busy       = s1_q.vld | s2_q.vld | done_q | out_valid_q;
  assign issue      = (state_q == StRun) & ~((k_q == FirstIdx) & busy);
  assign wdata      = {elem3_i, elem2_i, elem1_i, elem0_i};

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    row_d      = row_q;
    k_d        = k_q;
    case (state_q)
      StLoad: begin
        if (accept) begin
          load_cnt_d = load_cnt_q + 3'd1;
          if (load_cnt_q == 3'd7) begin
            state_d = StRun;
          end
        end
      end
      StRun: begin
        if (issue) begin
          k_d = k_q + idx_t'(1);
          if (k_q == LastIdx) begin
            row_d = row_q + idx_t'(1);
            if (row_q == LastIdx) begin
              state_d = StLoad;
            end
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  assign s1_d.vld = issue;
  assign s1_d.k   = k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      load_cnt_q  <= '0;
      row_q       <= '0;
      k_q         <= '0;
      s1_q        <= '0;
      s2_q        <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_cnt_q  <= load_cnt_d;
      row_q       <= row_d;
      k_q         <= k_d;
      s1_q        <= s1_d;
      s2_q        <= s1_q;
      done_q      <= s2_q.vld & (s2_q.k == LastIdx);
      out_valid_q <= out_valid_d;
    end
  end

  mm4_ram #(
    .WIDTH(RowWidth),
    .DEPTH(NumLanes)
  ) u_a_ram (
    .clk_i  (clk_i),
    .we_i   (accept & ~load_cnt_q[2]),
    .waddr_i(load_cnt_q[1:0]),
    .wdata_i(wdata),
    .raddr_i(row_q),
    .rdata_o(a_rdata)
  );

  mm4_ram #(
    .WIDTH(RowWidth),
    .DEPTH(NumLanes)
  ) u_b_ram (
    .clk_i  (clk_i),
    .we_i   (accept & load_cnt_q[2]),
    .waddr_i(load_cnt_q[1:0]),
    .wdata_i(wdata),
    .raddr_i(k_q),
    .rdata_o(b_rdata)
  );

  assign lane_ctl.mul_en    = s1_q.vld;
  assign lane_ctl.acc_en    = s2_q.vld;
  assign lane_ctl.acc_first = (s2_q.k == FirstIdx);

  assign a_sel = a_elems[s1_q.k];

  for (genvar j = 0; j < NumLanes; j++) begin : g_lane
    assign a_elems[j] = a_rdata[j*ElemWidth +: ElemWidth];
    assign b_elems[j] = b_rdata[j*ElemWidth +: ElemWidth];

    mm4_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk_i (clk_i),
      .ctl_i (lane_ctl),
      .a_i   (a_sel),
      .b_i   (b_elems[j]),
      .res_o (lane_res[j]),
      .sat_o (lane_sat[j])
    );
  end

  assign out_valid_d = done_q | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i) begin
    if (done_q) begin
      out_q     <= lane_res;
      out_row_q <= row_q - idx_t'(1);
      out_sat_q <= |lane_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out0_o      = out_q[0];
  assign out1_o      = out_q[1];
  assign out2_o      = out_q[2];
  assign out3_o      = out_q[3];
  assign row_index_o = out_row_q;
  assign last_row_o  = (out_row_q == LastIdx);
  assign saturated_o = out_sat_q;

  a_done_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !out_valid_q)
    else $error("row finished while the output register was still full");

  a_run_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (load_cnt_q == 3'd0))
    else $error("load counter not cleared during product computation");

  a_row_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && k_q == FirstIdx) |-> !s1_q.vld && !s2_q.vld && !out_valid_q)
    else $error("new row issued while an earlier row was still in flight");

endmodule
